@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the gap slot finder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SGSF_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgsf assertion failed");

// Assertion on the clk_i / rst_ni pair of the enclosing scope.
`define SGSF_ASSERT(label, prop) `SGSF_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ rtl/sgsf_pkg.sv @@
// ----------------------------------------------------------------------------
// sgsf_pkg
// Types, constants and the control store of the gap slot finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgsf_pkg;

  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned NUM_RESOURCES = 4;
  localparam int unsigned TIME_BITS     = 48;

  // Fixed field widths of the request and response items.
  localparam int unsigned SLOT_BITS = 7;
  localparam int unsigned RES_BITS  = 2;

  localparam int unsigned IDX_BITS  = $clog2(QUEUE_DEPTH);
  localparam int unsigned ADDR_BITS = RES_BITS + IDX_BITS;
  localparam int unsigned MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_FIND   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_CLAMPED = 2'd2
  } status_e;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_DISPATCH,
    UOP_RES_ZERO,
    UOP_CLEAR,
    UOP_APPEND,
    UOP_FIND_INIT,
    UOP_LOAD_LF,
    UOP_NS_CALC,
    UOP_EVAL,
    UOP_RES_HIT,
    UOP_RES_MISS,
    UOP_PUSH
  } uop_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_VALID,
    C_IS_CLEAR,
    C_IS_APPEND,
    C_IS_FIND,
    C_FIRST_ZERO,
    C_IX_END,
    C_MISS,
    C_OUT_FULL
  } cond_e;

  localparam int unsigned PC_BITS = 4;
  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t PC_FETCH      = 4'd0;
  localparam pc_t PC_DISPATCH   = 4'd1;
  localparam pc_t PC_TRY_APPEND = 4'd2;
  localparam pc_t PC_TRY_FIND   = 4'd3;
  localparam pc_t PC_OTHER      = 4'd4;
  localparam pc_t PC_CLEAR      = 4'd5;
  localparam pc_t PC_APPEND     = 4'd6;
  localparam pc_t PC_FIND       = 4'd7;
  localparam pc_t PC_LOAD_LF    = 4'd8;
  localparam pc_t PC_SCAN       = 4'd9;
  localparam pc_t PC_EVAL       = 4'd10;
  localparam pc_t PC_HIT        = 4'd11;
  localparam pc_t PC_MISS       = 4'd12;
  localparam pc_t PC_PUSH       = 4'd13;

  // One control word: operation, jump condition, jump target. When the
  // condition fails, a word marked last returns to fetch, others fall through.
  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    logic  last;
    pc_t   target;
  } ucode_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic valid;
    logic is_clear;
    logic is_append;
    logic is_find;
    logic first_zero;
    logic ix_end;
    logic miss;
    logic out_full;
  } flags_t;

  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH:      w = '{UOP_ACCEPT,    C_NO_VALID,   1'b0, PC_FETCH};
      PC_DISPATCH:   w = '{UOP_DISPATCH,  C_IS_CLEAR,   1'b0, PC_CLEAR};
      PC_TRY_APPEND: w = '{UOP_NOP,       C_IS_APPEND,  1'b0, PC_APPEND};
      PC_TRY_FIND:   w = '{UOP_NOP,       C_IS_FIND,    1'b0, PC_FIND};
      PC_OTHER:      w = '{UOP_RES_ZERO,  C_ALWAYS,     1'b0, PC_PUSH};
      PC_CLEAR:      w = '{UOP_CLEAR,     C_ALWAYS,     1'b0, PC_PUSH};
      PC_APPEND:     w = '{UOP_APPEND,    C_ALWAYS,     1'b0, PC_PUSH};
      PC_FIND:       w = '{UOP_FIND_INIT, C_FIRST_ZERO, 1'b0, PC_SCAN};
      PC_LOAD_LF:    w = '{UOP_LOAD_LF,   C_NEVER,      1'b0, PC_FETCH};
      PC_SCAN:       w = '{UOP_NS_CALC,   C_IX_END,     1'b0, PC_MISS};
      PC_EVAL:       w = '{UOP_EVAL,      C_MISS,       1'b0, PC_SCAN};
      PC_HIT:        w = '{UOP_RES_HIT,   C_ALWAYS,     1'b0, PC_PUSH};
      PC_MISS:       w = '{UOP_RES_MISS,  C_NEVER,      1'b0, PC_FETCH};
      PC_PUSH:       w = '{UOP_PUSH,      C_OUT_FULL,   1'b1, PC_PUSH};
      default:       w = '{UOP_NOP,       C_ALWAYS,     1'b0, PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sgsf_req_if.sv @@
// ----------------------------------------------------------------------------
// sgsf_req_if
// Request channel of the gap slot finder: valid, ready and one request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sgsf_req_if;
  import sgsf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [RES_BITS-1:0]  resource;
  logic [TIME_BITS-1:0] entry_ready;
  logic [TIME_BITS-1:0] entry_finish;
  logic [TIME_BITS-1:0] duration;
  logic [TIME_BITS-1:0] earliest_start;
  logic [SLOT_BITS-1:0] first_slot;

  modport source (
    output valid, req_type, resource, entry_ready, entry_finish, duration,
           earliest_start, first_slot,
    input  ready
  );

  modport sink (
    input  valid, req_type, resource, entry_ready, entry_finish, duration,
           earliest_start, first_slot,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sgsf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sgsf_rsp_if
// Response channel of the gap slot finder: valid, ready and one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sgsf_rsp_if;
  import sgsf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [SLOT_BITS-1:0] slot_index;
  logic [TIME_BITS-1:0] slot_start;
  logic [TIME_BITS:0]   slot_stop;

  modport source (
    output valid, status, slot_index, slot_start, slot_stop,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, slot_start, slot_stop,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sgsf_mem.sv @@
// ----------------------------------------------------------------------------
// sgsf_mem
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgsf_mem #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/sgsf_seq.sv @@
// ----------------------------------------------------------------------------
// sgsf_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgsf_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgsf_pkg::flags_t flags_i,
  output sgsf_pkg::ucode_t uc_o
);
  import sgsf_pkg::*;

  pc_t    pc_q, pc_d;
  ucode_t uc;
  logic   take;

  always_comb begin
    uc = ucode_rom(pc_q);
    unique case (uc.cond)
      C_ALWAYS:     take = 1'b1;
      C_NEVER:      take = 1'b0;
      C_NO_VALID:   take = !flags_i.valid;
      C_IS_CLEAR:   take = flags_i.is_clear;
      C_IS_APPEND:  take = flags_i.is_append;
      C_IS_FIND:    take = flags_i.is_find;
      C_FIRST_ZERO: take = flags_i.first_zero;
      C_IX_END:     take = flags_i.ix_end;
      C_MISS:       take = flags_i.miss;
      C_OUT_FULL:   take = flags_i.out_full;
      default:      take = 1'b0;
    endcase

    if (take) begin
      pc_d = uc.target;
    end else if (uc.last) begin
      pc_d = PC_FETCH;
    end else begin
      pc_d = pc_q + PC_BITS'(1);
    end
    uc_o = uc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/schedule_gap_slot_finder_unit.sv @@
// Flow: accept, dispatch, then clear, append, find or (other codes) zero the
// result, then push it; a find past slot 0 first loads the prior finish.
// Throughput: one request at a time; the next is taken once the result is in
// the output register. The scan costs a registered RAM read and a compare.
// Reset: asynchronous, active low; queue counts and control clear, the
// interval RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// schedule_gap_slot_finder_unit
// Per-resource interval queues with a first-fit gap search, run by a
// microcoded sequencer over a plain datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module schedule_gap_slot_finder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  sgsf_req_if.sink          req_i,
  sgsf_rsp_if.source        rsp_o
);
  import sgsf_pkg::*;

  ucode_t uc;
  flags_t flags;

  // Latched request.
  logic [1:0]           req_type_q, req_type_d;
  logic [RES_BITS-1:0]  res_q, res_d;
  logic [TIME_BITS-1:0] e_ready_q, e_ready_d;
  logic [TIME_BITS-1:0] e_finish_q, e_finish_d;
  logic [TIME_BITS-1:0] dur_q, dur_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [SLOT_BITS-1:0] first_q, first_d;

  // Scan state.
  logic [SLOT_BITS-1:0] cnt_q, cnt_d;
  status_e              status_q, status_d;
  logic [SLOT_BITS-1:0] ix_q, ix_d;
  logic [TIME_BITS-1:0] lf_q, lf_d;
  logic [TIME_BITS-1:0] ns_q, ns_d;
  logic [TIME_BITS:0]   nsd_q, nsd_d;

  // Result staging and output register.
  status_e              res_status_q, res_status_d;
  logic [SLOT_BITS-1:0] res_slot_q, res_slot_d;
  logic [TIME_BITS-1:0] res_start_q, res_start_d;
  logic [TIME_BITS:0]   res_stop_q, res_stop_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [SLOT_BITS-1:0] out_slot_q, out_slot_d;
  logic [TIME_BITS-1:0] out_start_q, out_start_d;
  logic [TIME_BITS:0]   out_stop_q, out_stop_d;

  logic [SLOT_BITS-1:0] count_q [NUM_RESOURCES];
  logic [SLOT_BITS-1:0] count_d [NUM_RESOURCES];

  // Interval RAM port signals.
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [2*TIME_BITS-1:0] mem_rdata;
  logic [TIME_BITS-1:0]   rd_ready, rd_finish;
  logic [SLOT_BITS-1:0]   first_m1;
  logic [SLOT_BITS-1:0]   cur_count;
  logic [TIME_BITS-1:0]   ns_sel;
  logic                   out_full, hit;

  sgsf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uc_o    (uc)
  );

  sgsf_mem #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({e_ready_q, e_finish_q}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_ready  = mem_rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_finish = mem_rdata[TIME_BITS-1:0];
  assign first_m1  = first_q - SLOT_BITS'(1);
  assign cur_count = count_q[res_q];
  assign out_full  = out_valid_q && !rsp_o.ready;
  assign ns_sel    = (lf_q < start_q) ? start_q : lf_q;

  // An entry that finished before the earliest start offers no gap; a
  // zero-ready entry at the head of the queue leaves none either.
  assign hit = (rd_finish >= start_q) && ({1'b0, rd_ready} >= nsd_q) &&
               ((ix_q != '0) || (rd_ready != '0));

  assign mem_waddr = {res_q, cnt_q[IDX_BITS-1:0]};
  assign mem_we    = (uc.uop == UOP_APPEND) && (cnt_q < SLOT_BITS'(QUEUE_DEPTH));
  assign mem_raddr = (uc.uop == UOP_FIND_INIT) ? {res_q, first_m1[IDX_BITS-1:0]}
                                               : {res_q, ix_q[IDX_BITS-1:0]};

  always_comb begin
    flags.valid      = req_i.valid;
    flags.is_clear   = (req_type_q == REQ_CLEAR);
    flags.is_append  = (req_type_q == REQ_APPEND);
    flags.is_find    = (req_type_q == REQ_FIND);
    flags.first_zero = (first_q == '0);
    flags.ix_end     = (ix_q >= cnt_q);
    flags.miss       = !hit;
    flags.out_full   = out_full;
  end

  always_comb begin
    req_type_d   = req_type_q;
    res_d        = res_q;
    e_ready_d    = e_ready_q;
    e_finish_d   = e_finish_q;
    dur_d        = dur_q;
    start_d      = start_q;
    first_d      = first_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    ix_d         = ix_q;
    lf_d         = lf_q;
    ns_d         = ns_q;
    nsd_d        = nsd_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_start_d  = res_start_q;
    res_stop_d   = res_stop_q;
    out_valid_d  = out_full;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_start_d  = out_start_q;
    out_stop_d   = out_stop_q;
    count_d      = count_q;

    unique case (uc.uop) inside
      UOP_ACCEPT: begin
        if (req_i.valid) begin
          req_type_d = req_i.req_type;
          res_d      = req_i.resource;
          e_ready_d  = req_i.entry_ready;
          e_finish_d = req_i.entry_finish;
          dur_d      = req_i.duration;
          start_d    = req_i.earliest_start;
          first_d    = req_i.first_slot;
        end
      end
      UOP_DISPATCH: begin
        cnt_d = cur_count;
        if (first_q > cur_count) begin
          first_d  = cur_count;
          status_d = ST_CLAMPED;
        end else begin
          status_d = ST_OK;
        end
      end
      UOP_RES_ZERO, UOP_CLEAR: begin
        res_status_d = ST_OK;
        res_slot_d   = '0;
        res_start_d  = '0;
        res_stop_d   = '0;
        if (uc.uop == UOP_CLEAR) begin
          count_d[res_q] = '0;
        end
      end
      UOP_APPEND: begin
        res_slot_d  = cnt_q;
        res_start_d = '0;
        res_stop_d  = '0;
        if (cnt_q < SLOT_BITS'(QUEUE_DEPTH)) begin
          res_status_d   = ST_OK;
          count_d[res_q] = cnt_q + SLOT_BITS'(1);
        end else begin
          res_status_d = ST_FULL;
        end
      end
      UOP_FIND_INIT: begin
        ix_d = first_q;
        lf_d = '0;
      end
      UOP_LOAD_LF: begin
        lf_d = rd_finish;
      end
      UOP_NS_CALC: begin
        ns_d  = ns_sel;
        nsd_d = {1'b0, ns_sel} + {1'b0, dur_q};
      end
      UOP_EVAL: begin
        if (!hit) begin
          lf_d = rd_finish;
          ix_d = ix_q + SLOT_BITS'(1);
        end
      end
      UOP_RES_HIT, UOP_RES_MISS: begin
        res_status_d = status_q;
        res_slot_d   = (uc.uop == UOP_RES_HIT) ? ix_q : cnt_q;
        res_start_d  = ns_q;
        res_stop_d   = nsd_q;
      end
      UOP_PUSH: begin
        if (!out_full) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_start_d  = res_start_q;
          out_stop_d   = res_stop_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_type_q   <= req_type_d;
    res_q        <= res_d;
    e_ready_q    <= e_ready_d;
    e_finish_q   <= e_finish_d;
    dur_q        <= dur_d;
    start_q      <= start_d;
    first_q      <= first_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    ix_q         <= ix_d;
    lf_q         <= lf_d;
    ns_q         <= ns_d;
    nsd_q        <= nsd_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_start_q  <= res_start_d;
    res_stop_q   <= res_stop_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_start_q  <= out_start_d;
    out_stop_q   <= out_stop_d;
  end

  assign req_i.ready      = (uc.uop == UOP_ACCEPT);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_index = out_slot_q;
  assign rsp_o.slot_start = out_start_q;
  assign rsp_o.slot_stop  = out_stop_q;

endmodule

`default_nettype wire

@@ rtl/sgsf_checker.sv @@
// ----------------------------------------------------------------------------
// sgsf_checker
// Port-level checks of the gap slot finder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sgsf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic                           rsp_valid_i,
  input  logic                           rsp_ready_i,
  input  logic [1:0]                     rsp_status_i,
  input  logic [sgsf_pkg::SLOT_BITS-1:0] rsp_slot_index_i,
  input  logic [sgsf_pkg::TIME_BITS-1:0] rsp_slot_start_i,
  input  logic [sgsf_pkg::TIME_BITS:0]   rsp_slot_stop_i
);
  import sgsf_pkg::*;

  logic full_shape_ok;

  assign full_shape_ok = (rsp_slot_index_i == SLOT_BITS'(QUEUE_DEPTH)) &&
                         (rsp_slot_start_i == '0);

  // A stalled result stays offered with its stop time unchanged.
  `SGSF_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
  `SGSF_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_slot_stop_i))

  // Requests are processed one at a time.
  `SGSF_ASSERT(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i)

  // A dropped append reports a full queue at slot QUEUE_DEPTH and a zero start.
  `SGSF_ASSERT(a_full_shape, rsp_valid_i && rsp_status_i == ST_FULL |-> full_shape_ok)

  // The stop time never lies before the start time.
  `SGSF_ASSERT(a_stop_order, rsp_valid_i |-> rsp_slot_stop_i >= (TIME_BITS + 1)'(rsp_slot_start_i))

endmodule

bind schedule_gap_slot_finder_unit sgsf_checker u_sgsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_slot_index_i (rsp_o.slot_index),
  .rsp_slot_start_i (rsp_o.slot_start),
  .rsp_slot_stop_i  (rsp_o.slot_stop)
);

`default_nettype wire
